// File: hw/rtl/wrc_pkg.sv
// ----------------------------------------------------------------------------
// wrc_pkg
// Shared types and constants of the weighted running covariance block.
// ----------------------------------------------------------------------------
`default_nettype none
package wrc_pkg;
    localparam int unsigned NMAX     = 4;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned WTOT_W   = 48;
    localparam int unsigned NUM_REGS = 4;

    typedef logic [1:0] reg_idx_t;

    typedef enum logic [1:0] {
        REG_MEAN_0 = 2'd0,
        REG_MEAN_1 = 2'd1,
        REG_MEAN_2 = 2'd2,
        REG_MEAN_3 = 2'd3
    } reg_code_t;

    typedef struct packed {
        logic        restart;
        logic [31:0] weight;
        logic [31:0] sample_0;
        logic [31:0] sample_1;
        logic [31:0] sample_2;
        logic [31:0] sample_3;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] cov_value;
        logic        last_entry;
    } out_item_t;

    typedef struct packed {
        logic        cfg_index_hi;
        reg_idx_t    cfg_index;
        logic [31:0] cfg_value;
    } cfg_item_t;

    // saturate a signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sh0_0000_0000_7FFF_FFFF;
        lo = -66'sh0_0000_0000_8000_0000;
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/wrc_if.sv
// ----------------------------------------------------------------------------
// wrc_in_if / wrc_out_if / wrc_cfg_if
// Valid/ready channels of the weighted running covariance block.
// ----------------------------------------------------------------------------
`default_nettype none
interface wrc_in_if;
    logic                 valid;
    logic                 ready;
    logic                 restart;
    logic [31:0]          weight;
    logic signed [31:0]   sample_0;
    logic signed [31:0]   sample_1;
    logic signed [31:0]   sample_2;
    logic signed [31:0]   sample_3;
    modport source (output valid, restart, weight, sample_0, sample_1, sample_2, sample_3,
                    input ready);
    modport sink   (input valid, restart, weight, sample_0, sample_1, sample_2, sample_3,
                    output ready);
endinterface

interface wrc_out_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           row;
    logic [1:0]           col;
    logic signed [31:0]   cov_value;
    logic                 last_entry;
    modport source (output valid, row, col, cov_value, last_entry, input ready);
    modport sink   (input valid, row, col, cov_value, last_entry, output ready);
endinterface

interface wrc_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/wrc_ram.sv
// ----------------------------------------------------------------------------
// wrc_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
`default_nettype none
module wrc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/wrc_div.sv
// ----------------------------------------------------------------------------
// wrc_div
// Restoring divider, one quotient bit per cycle: f = floor(w*2^31 / W).
// Quotient fits in 32 bits because w <= W.
// ----------------------------------------------------------------------------
`default_nettype none
module wrc_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] weight,
    input  wire logic [47:0] divisor,
    output logic             done,
    output logic [31:0]      quot
);
    logic [63:0] num_reg,  num_next;
    logic [48:0] rem_reg,  rem_next;
    logic [31:0] q_reg,    q_next;
    logic [47:0] dvs_reg,  dvs_next;
    logic [6:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic [48:0] trial;

    assign quot = q_reg;
    assign done = busy_reg && (cnt_reg == 7'd0);

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[47:0], num_reg[63]};
        if (start)
        begin
            num_next  = {1'b0, weight, 31'd0};
            rem_next  = '0;
            q_next    = '0;
            dvs_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'd0)
                busy_next = 1'b0;
            else
            begin
                num_next = {num_reg[62:0], 1'b0};
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_next = trial - {1'b0, dvs_reg};
                    q_next   = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    q_next   = {q_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg - 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end
endmodule
`default_nettype wire

// File: hw/rtl/weighted_running_covariance.sv
// ----------------------------------------------------------------------------
// weighted_running_covariance
// Incremental weighted covariance of a DIM-element sample vector, stored in
// a 16-entry RAM and updated read-modify-write, one entry at a time.
// ----------------------------------------------------------------------------
//  channel   | dir | payload
//  in_ch     | in  | restart, weight, sample_0..3
//  out_ch    | out | row, col, cov_value, last_entry
//  cfg_ch    | in  | index, data (mean_0..mean_3)
//
//  One item passes through the idle accept state, then the serial divider that
//  forms w/W, then a six-step read/multiply/diff/scale/sum/write pass per
//  entry. A restart item skips the divider.
//  A stalled output holds the pass; the next item is taken once the last beat
//  leaves. Reset clears the means, total weight and entry valid bits.
`default_nettype none
module weighted_running_covariance #(
    parameter int unsigned DIM = 4
) (
    input wire logic  clk,
    input wire logic  rst_n,
    wrc_in_if.sink    in_ch,
    wrc_out_if.source out_ch,
    wrc_cfg_if.sink   cfg_ch
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_DIV   = 8'b00000010,
        S_RD    = 8'b00000100,
        S_MUL   = 8'b00001000,
        S_DIFF  = 8'b00010000,
        S_SCALE = 8'b00100000,
        S_ACC   = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] mean_reg [wrc_pkg::NMAX];
    logic signed [31:0] d_reg    [wrc_pkg::NMAX];
    logic [wrc_pkg::WTOT_W-1:0] wtot_reg;
    logic [15:0] vld_reg;
    logic        rst_item_reg;
    logic [31:0] f_reg;
    logic [1:0]  r_reg, c_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] p_reg;
    logic signed [32:0] diff_reg;
    logic signed [31:0] cur_reg;
    logic signed [31:0] v_reg;
    logic signed [65:0] scl_reg;

    logic        div_start, div_done;
    logic [31:0] div_q;
    logic [31:0] ram_rdata;
    logic        ram_we;
    logic [wrc_pkg::ADDR_W-1:0] addr;
    logic        last_pos;
    logic [48:0] wsum;
    logic [47:0] wnew;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign addr     = {r_reg, c_reg};
    assign last_pos = (r_reg == 2'(DIM-1)) && (c_reg == 2'(DIM-1));
    assign wsum     = {17'd0, in_ch.weight} + {1'b0, wtot_reg};
    assign wnew     = wsum[48] ? 48'hFFFF_FFFF_FFFF : wsum[47:0];
    assign div_start = in_ch.valid && in_ch.ready && !in_ch.restart;
    assign ram_we   = (state_reg == S_OUT) && out_ch.ready;

    assign out_ch.valid      = (state_reg == S_OUT);
    assign out_ch.row        = r_reg;
    assign out_ch.col        = c_reg;
    assign out_ch.cov_value  = v_reg;
    assign out_ch.last_entry = last_pos;

    wrc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .weight  (in_ch.weight),
        .divisor (wnew),
        .done    (div_done),
        .quot    (div_q)
    );

    wrc_ram #(.WIDTH(32), .DEPTH(16)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (v_reg),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_ch.valid) state_next = in_ch.restart ? S_RD : S_DIV;
            S_DIV:   if (div_done) state_next = S_RD;
            S_RD:    state_next = S_MUL;
            S_MUL:   state_next = S_DIFF;
            S_DIFF:  state_next = S_SCALE;
            S_SCALE: state_next = S_ACC;
            S_ACC:   state_next = S_OUT;
            S_OUT:   if (out_ch.ready) state_next = last_pos ? S_IDLE : S_RD;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wtot_reg  <= '0;
            vld_reg   <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
            for (int i = 0; i < wrc_pkg::NMAX; i++)
                mean_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_ch.valid && cfg_ch.index < 8'(wrc_pkg::NUM_REGS))
                mean_reg[cfg_ch.index[1:0]] <= cfg_ch.data;
            if (in_ch.valid && in_ch.ready)
            begin
                wtot_reg <= in_ch.restart ? {16'd0, in_ch.weight} : wnew;
                r_reg    <= '0;
                c_reg    <= '0;
            end
            if (ram_we)
            begin
                vld_reg[addr] <= 1'b1;
                // advance row-major
                if (c_reg == 2'(DIM-1))
                begin
                    c_reg <= '0;
                    r_reg <= r_reg + 2'd1;
                end
                else
                    c_reg <= c_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            rst_item_reg <= in_ch.restart;
            f_reg        <= '0;
            d_reg[0] <= wrc_pkg::sat32(66'(in_ch.sample_0) - 66'(mean_reg[0]));
            d_reg[1] <= wrc_pkg::sat32(66'(in_ch.sample_1) - 66'(mean_reg[1]));
            d_reg[2] <= wrc_pkg::sat32(66'(in_ch.sample_2) - 66'(mean_reg[2]));
            d_reg[3] <= wrc_pkg::sat32(66'(in_ch.sample_3) - 66'(mean_reg[3]));
        end
        if (state_reg == S_DIV && div_done)
            f_reg <= (wtot_reg == '0) ? 32'd0 : div_q;
        if (state_reg == S_MUL)
        begin
            prod_reg <= 64'(d_reg[r_reg]) * 64'(d_reg[c_reg]);
            cur_reg  <= vld_reg[addr] ? ram_rdata : 32'sd0;
        end
        if (state_reg == S_DIFF)
        begin
            p_reg    <= wrc_pkg::sat32(66'(prod_reg >>> 16));
            diff_reg <= 33'(wrc_pkg::sat32(66'(prod_reg >>> 16))) - 33'(cur_reg);
        end
        if (state_reg == S_SCALE)
            scl_reg <= 66'(diff_reg) * $signed({34'd0, f_reg});
        if (state_reg == S_ACC)
            v_reg <= rst_item_reg ? p_reg
                     : wrc_pkg::sat32(66'(cur_reg) + (scl_reg >>> 31));
    end
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives weighted samples into the covariance block, predicts each 16-entry
// matrix in fixed point and compares every output beat in order, across
// several mean settings and with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    localparam int N = 4;
    localparam logic [47:0] WSAT = 48'hFFFF_FFFF_FFFF;
    localparam longint CYCLE_LIMIT = 1500000;

    logic clk;
    logic rst_n;

    wrc_in_if  in_ch();
    wrc_out_if out_ch();
    wrc_cfg_if cfg_ch();

    weighted_running_covariance #(.DIM(N)) dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
    );

    // predictor state
    logic signed [31:0] mean_q [N];
    logic signed [31:0] cov_q  [16];
    logic [47:0]        wtot_q;

    wrc_pkg::in_item_t  sample_q [$];
    wrc_pkg::out_item_t entry_q  [$];

    int     errors;
    int     mismatches;
    longint cycles;
    bit     hold_off;
    int     in_gap;
    int     out_gap;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic signed [31:0] clip32(input logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -128'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // update the running matrix and queue the sixteen expected entries
    task automatic predict_matrix(input wrc_pkg::in_item_t s);
        logic signed [31:0]  dv [N];
        logic signed [31:0]  samp [N];
        logic [47:0]         wsum;
        logic [48:0]         wwide;
        logic [127:0]        frac;
        logic signed [127:0] prod;
        logic signed [127:0] diff;
        logic signed [31:0]  p;
        logic signed [31:0]  v;
        wrc_pkg::out_item_t  e;
        samp[0] = s.sample_0;
        samp[1] = s.sample_1;
        samp[2] = s.sample_2;
        samp[3] = s.sample_3;
        for (int i = 0; i < N; i++)
            dv[i] = clip32(128'(samp[i]) - 128'(mean_q[i]));
        frac = '0;
        if (s.restart)
            wtot_q = {16'd0, s.weight};
        else
        begin
            wwide = {1'b0, wtot_q} + {17'd0, s.weight};
            wsum = (wwide > {1'b0, WSAT}) ? WSAT : wwide[47:0];
            wtot_q = wsum;
            if (wsum != 0)
                frac = ({96'd0, s.weight} << 31) / {80'd0, wsum};
        end
        for (int r = 0; r < N; r++)
            for (int c = 0; c < N; c++)
            begin
                prod = 128'(dv[r]) * 128'(dv[c]);
                p = clip32(prod >>> 16);
                if (s.restart)
                    v = p;
                else
                begin
                    diff = 128'(p) - 128'(cov_q[r*4+c]);
                    diff = (diff * $signed(frac)) >>> 31;
                    v = clip32(128'(cov_q[r*4+c]) + diff);
                end
                cov_q[r*4+c] = v;
                e.row = r[1:0];
                e.col = c[1:0];
                e.cov_value = v;
                e.last_entry = (r == N-1) && (c == N-1);
                entry_q = {entry_q, e};
            end
    endtask

    // driver: present the oldest pending sample, random gap between beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_matrix(sample_q.pop_front());
                in_gap = $urandom_range(0, 3);
            end
            if (in_gap > 0)
            begin
                in_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (sample_q.size() > 0)
            begin
                in_ch.valid    <= 1'b1;
                in_ch.restart  <= sample_q[0].restart;
                in_ch.weight   <= sample_q[0].weight;
                in_ch.sample_0 <= sample_q[0].sample_0;
                in_ch.sample_1 <= sample_q[0].sample_1;
                in_ch.sample_2 <= sample_q[0].sample_2;
                in_ch.sample_3 <= sample_q[0].sample_3;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // monitor: compare each accepted beat with the oldest expected entry
    always @(posedge clk or negedge rst_n)
    begin
        wrc_pkg::out_item_t exp_e;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            cycles++;
            if (out_ch.valid && out_ch.ready)
            begin
                if (entry_q.size() == 0)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("unexpected beat row %0d col %0d value %h",
                                 out_ch.row, out_ch.col, out_ch.cov_value);
                end
                else
                begin
                    exp_e = entry_q.pop_front();
                    if (out_ch.row !== exp_e.row || out_ch.col !== exp_e.col ||
                        out_ch.cov_value !== exp_e.cov_value ||
                        out_ch.last_entry !== exp_e.last_entry)
                    begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("mismatch: exp %0d,%0d %h %b got %0d,%0d %h %b",
                                     exp_e.row, exp_e.col, exp_e.cov_value,
                                     exp_e.last_entry, out_ch.row, out_ch.col,
                                     out_ch.cov_value, out_ch.last_entry);
                    end
                end
                out_gap = $urandom_range(0, 3);
            end
            if (hold_off)
                out_ch.ready <= 1'b0;
            else if (out_gap > 0)
            begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // hold valid across back-to-back writes; the caller drops it
    task automatic write_mean(input wrc_pkg::reg_code_t idx, input logic [31:0] val);
        cfg_ch.index <= 8'(idx);
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        mean_q[idx] = val;
    endtask

    task automatic set_means(input logic [31:0] m0, m1, m2, m3);
        write_mean(wrc_pkg::REG_MEAN_0, m0);
        write_mean(wrc_pkg::REG_MEAN_1, m1);
        write_mean(wrc_pkg::REG_MEAN_2, m2);
        write_mean(wrc_pkg::REG_MEAN_3, m3);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic add_sample(input bit rs, input logic [31:0] w, s0, s1, s2, s3);
        wrc_pkg::in_item_t it;
        it.restart = rs;
        it.weight = w;
        it.sample_0 = s0;
        it.sample_1 = s1;
        it.sample_2 = s2;
        it.sample_3 = s3;
        sample_q = {sample_q, it};
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1, 32'h0004_0000);
        endcase
    endfunction

    task automatic add_random(input int count);
        for (int i = 0; i < count; i++)
            add_sample(($urandom_range(0, 9) == 0), rand_weight(), rand_elem(),
                       rand_elem(), rand_elem(), rand_elem());
    endtask

    // wait until every queued sample is matched, then let the block settle
    task automatic drain();
        while (sample_q.size() > 0 || entry_q.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        errors = 0;
        mismatches = 0;
        cycles = 0;
        hold_off = 1'b0;
        wtot_q = '0;
        for (int i = 0; i < N; i++) mean_q[i] = '0;
        for (int i = 0; i < 16; i++) cov_q[i] = '0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.restart = 1'b0;
        in_ch.weight = '0;
        in_ch.sample_0 = '0;
        in_ch.sample_1 = '0;
        in_ch.sample_2 = '0;
        in_ch.sample_3 = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero total weight, restart with zero weight, extremes
        add_sample(1'b0, 32'd0, 32'h0001_0000, 32'hFFFF_0000, 32'd0, 32'h0002_0000);
        add_sample(1'b1, 32'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'd3);
        add_sample(1'b0, 32'd0, 32'h0003_0000, 32'd1, 32'd2, 32'd3);
        add_sample(1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'hFFFE_0000, 32'd0);
        add_sample(1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000);
        add_sample(1'b0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        add_sample(1'b0, 32'd1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0010_0000, 32'd0);
        drain();

        // large total weight: many maximal weights without restart
        set_means(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000);
        add_sample(1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
        for (int i = 0; i < 12; i++)
            add_sample(1'b0, 32'hFFFF_FFFF, rand_elem(), rand_elem(), rand_elem(),
                       rand_elem());
        add_sample(1'b0, 32'd5, 32'h0001_0000, 32'd0, 32'd0, 32'd0);
        drain();

        set_means(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
        add_random(100);
        // long receiver stall while the sender keeps offering samples
        while (sample_q.size() > 90) @(posedge clk);
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
        drain();

        set_means($urandom, $urandom, $urandom, $urandom);
        add_random(150);
        drain();

        set_means(32'd0, 32'd0, 32'd0, 32'd0);
        add_random(130);
        drain();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end
endmodule

// File: weighted_running_covariance.f
hw/rtl/wrc_pkg.sv
hw/rtl/wrc_if.sv
hw/rtl/wrc_ram.sv
hw/rtl/wrc_div.sv
hw/rtl/weighted_running_covariance.sv
tb/sv/tb.sv
